// ===== sv/gwwb_pkg.sv =====
// Shared types and constants for the gray-world white balance block.
package gwwb_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV_LOAD,
    ST_DIV_RUN,
    ST_DIV_STORE,
    ST_REPORT
  } gwwb_state_t;

  localparam logic CMD_GATHER = 1'b0;
  localparam logic CMD_APPLY  = 1'b1;

  localparam logic KIND_PIXEL    = 1'b0;
  localparam logic KIND_ESTIMATE = 1'b1;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_BAD_MEAN = 2'd1;
  localparam logic [1:0] STATUS_NO_EST   = 2'd2;

  localparam logic [1:0] DIV_RED_RATIO  = 2'd0;
  localparam logic [1:0] DIV_BLUE_RATIO = 2'd1;
  localparam logic [1:0] DIV_RED_GAIN   = 2'd2;
  localparam logic [1:0] DIV_BLUE_GAIN  = 2'd3;

  localparam int RATIO_W    = 32;
  localparam int GAIN_W     = 40;
  localparam int RATIO_FRAC = 16;
  localparam int GAIN_FRAC  = 24;
  localparam int QUOT_W     = GAIN_W + 2;

  localparam logic [GAIN_W-1:0] GAIN_ONE = 40'h00_0100_0000;

  typedef struct packed {
    logic       gather;
    logic       apply;
    logic       div_load;
    logic       div_step;
    logic       div_store;
    logic [1:0] div_sel;
    logic       report_ok;
    logic       report_bad;
  } gwwb_cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic est_ok;
    logic div_last;
  } gwwb_status_t;

endpackage

// ===== sv/grey_world_white_balance_core.sv =====
// Gray-world auto white balance: top level joining controller and datapath.
//
// An FP16 RGBA pixel is taken as a transaction at a clock edge where start is
// high and busy is low. command selects the pass: gather adds R, G and B into
// exact fixed-point frame sums; apply scales R and B by the current gains.
// Results appear for one cycle with result_valid high; there is no back
// pressure, so a result is lost if the receiver does not sample it then.
// Apply pixels are taken one per clock while busy is low; each result
// passes the product, leading-one and rounding registers. Gather pixels
// that are not last give no result. A last gather pixel makes busy rise
// while the estimate is formed: a bad estimate is reported once the pipeline
// drains; a good one needs four quotients from one restoring divider at one
// bit per cycle. Apply pixels still in flight are delivered before the
// estimate. Reset clears the sums and flags, sets both gains to one and
// marks the estimate invalid; until a good estimate exists, apply passes
// pixels unchanged with status 2.
module grey_world_white_balance_core import gwwb_pkg::*; #(
  parameter int MAX_PIXELS_LOG2 = 22
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        command,
  input  logic [15:0] in_red,
  input  logic [15:0] in_green,
  input  logic [15:0] in_blue,
  input  logic [15:0] in_alpha,
  input  logic        last_pixel,
  output logic        result_valid,
  output logic        kind,
  output logic [15:0] out_red,
  output logic [15:0] out_green,
  output logic [15:0] out_blue,
  output logic [15:0] out_alpha,
  output logic [31:0] neutral_red,
  output logic [31:0] neutral_blue,
  output logic [1:0]  status,
  output logic        last
);

  gwwb_cmd_t    cmd;
  gwwb_status_t stat;

  gwwb_controller u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .command    (command),
    .last_pixel (last_pixel),
    .stat       (stat),
    .busy       (busy),
    .cmd        (cmd)
  );

  gwwb_datapath #(
    .MAX_PIXELS_LOG2 (MAX_PIXELS_LOG2)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .in_red       (in_red),
    .in_green     (in_green),
    .in_blue      (in_blue),
    .in_alpha     (in_alpha),
    .last_pixel   (last_pixel),
    .stat         (stat),
    .result_valid (result_valid),
    .kind         (kind),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue),
    .out_alpha    (out_alpha),
    .neutral_red  (neutral_red),
    .neutral_blue (neutral_blue),
    .status       (status),
    .last         (last)
  );

  a_est_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && (kind == KIND_ESTIMATE) |-> last)
    else $error("estimate result without last");

  a_est_status: assert property (@(posedge clk) disable iff (rst)
    result_valid && (kind == KIND_ESTIMATE) |-> (status != STATUS_NO_EST))
    else $error("estimate result with apply status");

  a_est_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid && (kind == KIND_ESTIMATE) |-> $past(busy))
    else $error("estimate result while idle");

  a_report_excl: assert property (@(posedge clk) disable iff (rst)
    (cmd.report_ok || cmd.report_bad) |-> !stat.pipe_busy && !cmd.apply)
    else $error("estimate report collides with pixel pipeline");

endmodule

// ===== sv/gwwb_controller.sv =====
// Sequencer for gather, estimate division and report of the white balance block.
module gwwb_controller import gwwb_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic         command,
  input  logic         last_pixel,
  input  gwwb_status_t stat,
  output logic         busy,
  output gwwb_cmd_t    cmd
);

  gwwb_state_t state, state_next;
  logic [1:0]  div_idx, div_idx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      div_idx <= DIV_RED_RATIO;
    end else begin
      state   <= state_next;
      div_idx <= div_idx_next;
    end
  end

  always_comb begin
    state_next   = state;
    div_idx_next = div_idx;
    busy         = 1'b1;
    cmd          = '0;
    cmd.div_sel  = div_idx;
    unique case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (command == CMD_GATHER) begin
            cmd.gather = 1'b1;
            if (last_pixel) state_next = ST_CHECK;
          end else begin
            cmd.apply = 1'b1;
          end
        end
      end
      ST_CHECK: begin
        // Pixels still in the scaling pipeline leave before the estimate.
        if (!stat.pipe_busy) begin
          if (stat.est_ok) begin
            div_idx_next = DIV_RED_RATIO;
            state_next   = ST_DIV_LOAD;
          end else begin
            cmd.report_bad = 1'b1;
            state_next     = ST_IDLE;
          end
        end
      end
      ST_DIV_LOAD: begin
        cmd.div_load = 1'b1;
        state_next   = ST_DIV_RUN;
      end
      ST_DIV_RUN: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_next = ST_DIV_STORE;
      end
      ST_DIV_STORE: begin
        cmd.div_store = 1'b1;
        if (div_idx == DIV_BLUE_GAIN) begin
          state_next = ST_REPORT;
        end else begin
          div_idx_next = div_idx + 2'd1;
          state_next   = ST_DIV_LOAD;
        end
      end
      ST_REPORT: begin
        cmd.report_ok = 1'b1;
        state_next    = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== sv/gwwb_datapath.sv =====
// Sums, shared restoring divider, gain scaling pipeline and result registers.
module gwwb_datapath import gwwb_pkg::*; #(
  parameter int MAX_PIXELS_LOG2 = 22
) (
  input  logic         clk,
  input  logic         rst,
  input  gwwb_cmd_t    cmd,
  input  logic [15:0]  in_red,
  input  logic [15:0]  in_green,
  input  logic [15:0]  in_blue,
  input  logic [15:0]  in_alpha,
  input  logic         last_pixel,
  output gwwb_status_t stat,
  output logic         result_valid,
  output logic         kind,
  output logic [15:0]  out_red,
  output logic [15:0]  out_green,
  output logic [15:0]  out_blue,
  output logic [15:0]  out_alpha,
  output logic [31:0]  neutral_red,
  output logic [31:0]  neutral_blue,
  output logic [1:0]   status,
  output logic         last
);

  localparam int SUM_BITS = 41 + MAX_PIXELS_LOG2;
  localparam int CNT_W    = $clog2(SUM_BITS + GAIN_FRAC + 2);
  localparam logic [CNT_W-1:0] CNT_RATIO = CNT_W'(SUM_BITS + RATIO_FRAC + 1);
  localparam logic [CNT_W-1:0] CNT_GAIN  = CNT_W'(SUM_BITS + GAIN_FRAC + 1);
  localparam logic [QUOT_W-1:0] RATIO_LIM2 =
    {{(QUOT_W-RATIO_W-1){1'b0}}, {(RATIO_W+1){1'b1}}};
  localparam logic [QUOT_W-1:0] GAIN_LIM2 =
    {{(QUOT_W-GAIN_W-1){1'b0}}, {(GAIN_W+1){1'b1}}};
  localparam logic [GAIN_W-1:0] RATIO_LIM = {{(GAIN_W-RATIO_W){1'b0}}, {RATIO_W{1'b1}}};
  localparam logic [GAIN_W-1:0] GAIN_LIM  = {GAIN_W{1'b1}};

  typedef struct packed {
    logic [50:0] prod;
    logic        sign;
    logic [4:0]  bige;
    logic        spec;
    logic [15:0] spec_val;
  } chan_a_t;

  typedef struct packed {
    logic [50:0]       prod;
    logic              sign;
    logic              spec;
    logic [15:0]       spec_val;
    logic              normal;
    logic signed [7:0] ef;
    logic signed [6:0] sh;
  } chan_b_t;

  // Exact half value as a two's complement fixed-point number with 24 fraction bits.
  function automatic logic [SUM_BITS-1:0] half_to_fix(input logic [15:0] h);
    logic [SUM_BITS-1:0] mag;
    if (h[14:10] == 5'd0) begin
      mag = {{(SUM_BITS-10){1'b0}}, h[9:0]};
    end else begin
      mag = {{(SUM_BITS-11){1'b0}}, 1'b1, h[9:0]} << (h[14:10] - 5'd1);
    end
    return h[15] ? (~mag + 1'b1) : mag;
  endfunction

  function automatic chan_a_t stage_a(input logic [15:0] h, input logic [GAIN_W-1:0] gain,
                                      input logic est);
    chan_a_t    c;
    logic [10:0] m;
    m          = (h[14:10] != 5'd0) ? {1'b1, h[9:0]} : {1'b0, h[9:0]};
    c.prod     = m * gain;
    c.sign     = h[15];
    c.bige     = (h[14:10] != 5'd0) ? h[14:10] : 5'd1;
    c.spec     = 1'b0;
    c.spec_val = h;
    if (!est) begin
      c.spec = 1'b1;
    end else if (h[14:10] == 5'h1F) begin
      c.spec = 1'b1;
      if (h[9:0] != 10'd0)    c.spec_val = h | 16'h0200;
      else if (gain == '0)    c.spec_val = 16'h7E00;
    end
    return c;
  endfunction

  function automatic chan_b_t stage_b(input chan_a_t a);
    chan_b_t    c;
    logic [5:0] p;
    p = 6'd0;
    for (int i = 0; i < 51; i++) begin
      if (a.prod[i]) p = 6'(i);
    end
    c.prod     = a.prod;
    c.sign     = a.sign;
    c.spec     = a.spec;
    c.spec_val = a.spec_val;
    c.ef       = $signed({2'b00, p}) + $signed({3'b000, a.bige}) - 8'sd34;
    c.normal   = (c.ef > 8'sd0);
    c.sh       = c.normal ? ($signed({1'b0, p}) - 7'sd10)
                          : (7'sd25 - $signed({2'b00, a.bige}));
    return c;
  endfunction

  // Scale by two to the minus sh, rounding to nearest even.
  function automatic logic [11:0] round_shift(input logic [50:0] v,
                                              input logic signed [6:0] sh);
    logic [62:0] wide;
    logic [50:0] q, mask, rem, half;
    logic [6:0]  nl;
    logic [5:0]  n;
    logic        inc;
    if (sh <= 7'sd0) begin
      nl   = 7'(-sh);
      wide = {12'd0, v} << nl;
      return wide[11:0];
    end
    n    = sh[5:0];
    q    = v >> n;
    mask = (51'd1 << n) - 51'd1;
    rem  = v & mask;
    half = 51'd1 << (n - 6'd1);
    inc  = (rem > half) || ((rem == half) && q[0]);
    return q[11:0] + {11'd0, inc};
  endfunction

  function automatic logic [15:0] stage_c(input chan_b_t b);
    logic [11:0]       m12;
    logic [10:0]       mant;
    logic signed [7:0] efa;
    if (b.spec) return b.spec_val;
    if (b.prod == '0) return {b.sign, 15'd0};
    m12 = round_shift(b.prod, b.sh);
    if (!b.normal) return {b.sign, 3'd0, m12};
    mant = m12[10:0];
    efa  = b.ef;
    if (m12[11]) begin
      mant = m12[11:1];
      efa  = b.ef + 8'sd1;
    end
    if (efa > 8'sd30) return {b.sign, 15'h7C00};
    return {b.sign, efa[4:0], mant[9:0]};
  endfunction

  logic [SUM_BITS-1:0] sum_red, sum_green, sum_blue;
  logic [2:0]          nonfinite_seen;
  logic [GAIN_W-1:0]   red_gain, blue_gain;
  logic                estimate_valid;
  logic [RATIO_W-1:0]  ratio_red, ratio_blue;

  logic [SUM_BITS-1:0] dnum, drem, dden, dnum_sel, rsh;
  logic [QUOT_W-1:0]   dq, q_nx, lim2, q_inc;
  logic                dsat, is_gain, ge;
  logic [CNT_W-1:0]    dcnt;
  logic [GAIN_W:0]     rnd;
  logic [GAIN_W-1:0]   lim, div_val;

  logic                v1, v2;
  chan_a_t             a_red, a_blue;
  chan_b_t             b_red, b_blue;
  logic [15:0]         a_green, a_alpha, b_green, b_alpha;
  logic                a_last, b_last;
  logic [1:0]          a_status, b_status;

  function automatic logic positive(input logic [SUM_BITS-1:0] s);
    return (s != '0) && !s[SUM_BITS-1];
  endfunction

  assign stat.pipe_busy = v1 | v2;
  assign stat.est_ok    = (nonfinite_seen == 3'd0) && positive(sum_red) &&
                          positive(sum_green) && positive(sum_blue);
  assign stat.div_last  = (dcnt == CNT_W'(1));

  // Divider operands for the four quotients of an estimate.
  always_comb begin
    case (cmd.div_sel)
      DIV_RED_RATIO:  begin dnum_sel = sum_red;   dden = sum_green; end
      DIV_BLUE_RATIO: begin dnum_sel = sum_blue;  dden = sum_green; end
      DIV_RED_GAIN:   begin dnum_sel = sum_green; dden = sum_red;   end
      default:        begin dnum_sel = sum_green; dden = sum_blue;  end
    endcase
    is_gain = (cmd.div_sel == DIV_RED_GAIN) || (cmd.div_sel == DIV_BLUE_GAIN);
    lim2    = is_gain ? GAIN_LIM2 : RATIO_LIM2;
    lim     = is_gain ? GAIN_LIM : RATIO_LIM;
    rsh     = {drem[SUM_BITS-2:0], dnum[SUM_BITS-1]};
    ge      = (rsh >= dden);
    q_nx    = {dq[QUOT_W-2:0], ge};
    // One extra quotient bit is kept, then rounded half away from zero.
    q_inc   = dq + QUOT_W'(1);
    rnd     = q_inc[QUOT_W-1:1];
    div_val = (dsat || (rnd > {1'b0, lim})) ? lim : rnd[GAIN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dcnt <= '0;
    end else if (cmd.div_load) begin
      dcnt <= is_gain ? CNT_GAIN : CNT_RATIO;
    end else if (cmd.div_step) begin
      dcnt <= dcnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      dnum <= dnum_sel;
      drem <= '0;
      dq   <= '0;
      dsat <= 1'b0;
    end else if (cmd.div_step) begin
      dnum <= dnum << 1;
      drem <= ge ? (rsh - dden) : rsh;
      if (!dsat) begin
        dq <= q_nx;
        if (q_nx > lim2) dsat <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_store) begin
      case (cmd.div_sel)
        DIV_RED_RATIO:  ratio_red  <= div_val[RATIO_W-1:0];
        DIV_BLUE_RATIO: ratio_blue <= div_val[RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_red        <= '0;
      sum_green      <= '0;
      sum_blue       <= '0;
      nonfinite_seen <= 3'd0;
      red_gain       <= GAIN_ONE;
      blue_gain      <= GAIN_ONE;
      estimate_valid <= 1'b0;
    end else if (cmd.gather) begin
      // A non-finite channel is flagged and left out of its sum.
      if (in_red[14:10] == 5'h1F)   nonfinite_seen[0] <= 1'b1;
      else                          sum_red <= sum_red + half_to_fix(in_red);
      if (in_green[14:10] == 5'h1F) nonfinite_seen[1] <= 1'b1;
      else                          sum_green <= sum_green + half_to_fix(in_green);
      if (in_blue[14:10] == 5'h1F)  nonfinite_seen[2] <= 1'b1;
      else                          sum_blue <= sum_blue + half_to_fix(in_blue);
    end else if (cmd.div_store && (cmd.div_sel == DIV_RED_GAIN)) begin
      red_gain <= div_val;
    end else if (cmd.div_store && (cmd.div_sel == DIV_BLUE_GAIN)) begin
      blue_gain <= div_val;
    end else if (cmd.report_ok || cmd.report_bad) begin
      sum_red        <= '0;
      sum_green      <= '0;
      sum_blue       <= '0;
      nonfinite_seen <= 3'd0;
      estimate_valid <= cmd.report_ok;
      if (cmd.report_bad) begin
        red_gain  <= GAIN_ONE;
        blue_gain <= GAIN_ONE;
      end
    end
  end

  // Scaling pipeline: product, leading-one search, rounding.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.apply;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      a_red    <= stage_a(in_red, red_gain, estimate_valid);
      a_blue   <= stage_a(in_blue, blue_gain, estimate_valid);
      a_green  <= in_green;
      a_alpha  <= in_alpha;
      a_last   <= last_pixel;
      a_status <= estimate_valid ? STATUS_OK : STATUS_NO_EST;
    end
    if (v1) begin
      b_red    <= stage_b(a_red);
      b_blue   <= stage_b(a_blue);
      b_green  <= a_green;
      b_alpha  <= a_alpha;
      b_last   <= a_last;
      b_status <= a_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= v2 | cmd.report_ok | cmd.report_bad;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.report_ok || cmd.report_bad) begin
      kind         <= KIND_ESTIMATE;
      out_red      <= 16'd0;
      out_green    <= 16'd0;
      out_blue     <= 16'd0;
      out_alpha    <= 16'd0;
      neutral_red  <= cmd.report_ok ? ratio_red : 32'd0;
      neutral_blue <= cmd.report_ok ? ratio_blue : 32'd0;
      status       <= cmd.report_ok ? STATUS_OK : STATUS_BAD_MEAN;
      last         <= 1'b1;
    end else if (v2) begin
      kind         <= KIND_PIXEL;
      out_red      <= stage_c(b_red);
      out_green    <= b_green;
      out_blue     <= stage_c(b_blue);
      out_alpha    <= b_alpha;
      neutral_red  <= 32'd0;
      neutral_blue <= 32'd0;
      status       <= b_status;
      last         <= b_last;
    end
  end

endmodule
